// File: design/gtc_pkg.sv
// gtc_pkg: shared types and constants of the glyph text console
// used by gtc_row_seq and glyph_text_console_unit; no dependencies
package gtc_pkg;

   localparam int COORD_W     = 13;
   localparam int GLYPH_W     = 7;
   localparam int COLOR_W     = 32;
   localparam int MASK_W      = 8;
   localparam int CODE_W      = 21;
   localparam int STORE_AW    = 11;
   localparam int GLYPH_WIDTH = 8;

   localparam logic [COORD_W-1:0] COORD_MAX = '1;

   // character codes
   localparam logic [CODE_W-1:0]  CODE_NEWLINE = 21'd10;
   localparam logic [CODE_W-1:0]  CODE_LIMIT   = 21'h7F;
   localparam logic [GLYPH_W-1:0] CODE_SUBST   = 7'h3F;

   // request and result kinds
   localparam logic REQ_CHAR    = 1'b0;
   localparam logic REQ_STORE   = 1'b1;
   localparam logic KIND_DRAW   = 1'b0;
   localparam logic KIND_SCROLL = 1'b1;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic               RST_ENABLE = 1'b1;
   localparam logic [COORD_W-1:0] RST_WIDTH  = 13'd1024;
   localparam logic [COORD_W-1:0] RST_HEIGHT = 13'd768;

   // one character handed to the row sequencer
   typedef struct packed {
      logic               valid;
      logic               scroll;
      logic               draw;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] ybase;
      logic [COLOR_W-1:0] color;
      logic [GLYPH_W-1:0] glyph;
   } load_type;

   // sequencer status back to the top level
   typedef struct packed {
      logic busy;
      logic final_issue;
   } seq_stat_type;

   // one result beat in flight, mask joins from the glyph memory
   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } beat_type;

endpackage

// File: design/gtc_glyph_mem.sv
// gtc_glyph_mem: glyph row store, one write and one read port
// read data registered, read-first on a same-address collision; no dependencies
module gtc_glyph_mem #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          wen,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          ren,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] glyph_ram_ff [DEPTH];
   logic [7:0] rdata_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wen) begin
         glyph_ram_ff[waddr] <= wdata;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (ren) begin
         rdata_ff <= glyph_ram_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/gtc_row_seq.sv
// gtc_row_seq: issues the scroll beat and the glyph row reads of one character
// depends on gtc_pkg; drives the read port of gtc_glyph_mem
module gtc_row_seq #(
   parameter int FONT_ROWS  = 16,
   parameter int NUM_GLYPHS = 128
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  gtc_pkg::load_type                           load,
   input  logic                                        advance,
   output gtc_pkg::seq_stat_type                       stat,
   output logic                                        ren,
   output logic [$clog2(NUM_GLYPHS*FONT_ROWS)-1:0]     raddr,
   output logic                                        s1_valid,
   output gtc_pkg::beat_type                           s1_beat
);

   localparam int AW = $clog2(NUM_GLYPHS * FONT_ROWS);
   localparam int RW = $clog2(FONT_ROWS);
   localparam logic [RW-1:0] ROW_LAST = RW'(FONT_ROWS - 1);

   logic                           busy_ff, busy_in;
   logic                           scroll_pend_ff, scroll_pend_in;
   logic                           draw_ff, draw_in;
   logic [RW-1:0]                  row_idx_ff, row_idx_in;
   logic [gtc_pkg::COORD_W-1:0]    x_ff, x_in;
   logic [gtc_pkg::COORD_W-1:0]    ybase_ff, ybase_in;
   logic [gtc_pkg::COLOR_W-1:0]    color_ff, color_in;
   logic [gtc_pkg::GLYPH_W-1:0]    glyph_ff, glyph_in;
   logic                           s1_valid_ff, s1_valid_in;
   gtc_pkg::beat_type              s1_beat_ff, s1_beat_in;
   logic                           issue;
   logic                           final_issue;

   assign issue       = busy_ff && advance;
   assign final_issue = issue && (scroll_pend_ff ? !draw_ff : (row_idx_ff == ROW_LAST));

   // beat sequencing, a new character loads on the final beat of the last one
   always_comb begin
      busy_in        = busy_ff;
      scroll_pend_in = scroll_pend_ff;
      draw_in        = draw_ff;
      row_idx_in     = row_idx_ff;
      x_in           = x_ff;
      ybase_in       = ybase_ff;
      color_in       = color_ff;
      glyph_in       = glyph_ff;
      if (issue) begin
         if (scroll_pend_ff) begin
            scroll_pend_in = 1'b0;
         end else begin
            row_idx_in = row_idx_ff + 1'b1;
         end
         if (final_issue) begin
            busy_in = 1'b0;
         end
      end
      if (load.valid) begin
         busy_in        = 1'b1;
         scroll_pend_in = load.scroll;
         draw_in        = load.draw;
         row_idx_in     = '0;
         x_in           = load.x;
         ybase_in       = load.ybase;
         color_in       = load.color;
         glyph_in       = load.glyph;
      end
   end

   // beat issued into the read stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_beat_in  = s1_beat_ff;
      if (advance) begin
         s1_valid_in      = issue;
         s1_beat_in.last  = final_issue;
         if (scroll_pend_ff) begin
            s1_beat_in.kind  = gtc_pkg::KIND_SCROLL;
            s1_beat_in.x     = '0;
            s1_beat_in.y     = '0;
            s1_beat_in.color = '0;
         end else begin
            s1_beat_in.kind  = gtc_pkg::KIND_DRAW;
            s1_beat_in.x     = x_ff;
            s1_beat_in.y     = ybase_ff + gtc_pkg::COORD_W'(row_idx_ff);
            s1_beat_in.color = color_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         scroll_pend_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         scroll_pend_ff <= scroll_pend_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      draw_ff    <= draw_in;
      row_idx_ff <= row_idx_in;
      x_ff       <= x_in;
      ybase_ff   <= ybase_in;
      color_ff   <= color_in;
      glyph_ff   <= glyph_in;
      s1_beat_ff <= s1_beat_in;
   end

   // glyph row read address
   assign ren   = issue && !scroll_pend_ff;
   assign raddr = AW'(32'(glyph_ff) * 32'(FONT_ROWS) + 32'(row_idx_ff));

   assign stat.busy        = busy_ff;
   assign stat.final_issue = final_issue;
   assign s1_valid         = s1_valid_ff;
   assign s1_beat          = s1_beat_ff;

endmodule

// File: design/glyph_text_console_unit.sv
// glyph_text_console_unit: top level of the glyph text console
// depends on gtc_pkg, gtc_glyph_mem and gtc_row_seq
// path: an accepted character passes the sequencer state, the read stage and the output
//   register before its first result; a drawn glyph gives FONT_ROWS results, one more with a scroll
// throughput: one result per cycle while rsp_stall is low, set by the single read port
//   of the glyph memory; store writes and characters that give no result load no beats
// reset: cursor and control cleared, registers to defaults; glyph memory not cleared
module glyph_text_console_unit #(
   parameter int FONT_ROWS  = 16,
   parameter int NUM_GLYPHS = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [gtc_pkg::CODE_W-1:0]    req_char_code,
   input  logic [gtc_pkg::COLOR_W-1:0]   req_ink_color,
   input  logic [gtc_pkg::STORE_AW-1:0]  req_store_addr,
   input  logic [gtc_pkg::MASK_W-1:0]    req_store_byte,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [gtc_pkg::COORD_W-1:0]   rsp_pixel_x,
   output logic [gtc_pkg::COORD_W-1:0]   rsp_pixel_y,
   output logic [gtc_pkg::MASK_W-1:0]    rsp_row_mask,
   output logic [gtc_pkg::COLOR_W-1:0]   rsp_pen_color,
   output logic                          rsp_last,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [3:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int DEPTH = NUM_GLYPHS * FONT_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = gtc_pkg::COORD_W;
   localparam logic [CW:0] ROWS_X = (CW+1)'(FONT_ROWS);

   logic                      enable_ff;
   logic [CW-1:0]             width_ff;
   logic [CW-1:0]             height_ff;
   logic [CW-1:0]             cursor_col_ff, cursor_col_in;
   logic [CW-1:0]             cursor_row_ff, cursor_row_in;
   logic                      csr_write;
   logic                      req_fire;
   logic                      char_fire;
   logic                      store_fire;
   logic                      is_newline;
   logic                      scroll;
   logic [CW:0]               row_sum;
   logic [CW-1:0]             row_a;
   logic [CW:0]               col_n;
   logic [CW:0]               row_n;
   logic                      wrap;
   logic [gtc_pkg::GLYPH_W-1:0] glyph;
   gtc_pkg::load_type         load;
   gtc_pkg::seq_stat_type     stat;
   logic                      advance;
   logic                      ren;
   logic [AW-1:0]             raddr;
   logic [7:0]                rdata;
   logic                      s1_valid;
   gtc_pkg::beat_type         s1_beat;
   logic                      out_valid_ff, out_valid_in;
   gtc_pkg::beat_type         out_beat_ff, out_beat_in;
   logic [7:0]                out_mask_ff, out_mask_in;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= gtc_pkg::RST_ENABLE;
         width_ff  <= gtc_pkg::RST_WIDTH;
         height_ff <= gtc_pkg::RST_HEIGHT;
      end else if (csr_write) begin
         case (paddr[3:2])
            gtc_pkg::REG_ENABLE: enable_ff <= pwdata[0];
            gtc_pkg::REG_WIDTH:  width_ff  <= pwdata[CW-1:0];
            gtc_pkg::REG_HEIGHT: height_ff <= pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         gtc_pkg::REG_ENABLE: prdata = {31'd0, enable_ff};
         gtc_pkg::REG_WIDTH:  prdata = {{(32-CW){1'b0}}, width_ff};
         gtc_pkg::REG_HEIGHT: prdata = {{(32-CW){1'b0}}, height_ff};
         default:             prdata = '0;
      endcase
   end

   // request handshake: a new item enters while the sequencer is idle or with the final beat of the previous one
   assign req_stall  = stat.busy && !stat.final_issue;
   assign req_fire   = req_valid && !req_stall;
   assign char_fire  = req_fire && (req_type == gtc_pkg::REQ_CHAR) && enable_ff;
   assign store_fire = req_fire && (req_type == gtc_pkg::REQ_STORE) &&
                       (32'(req_store_addr) < 32'(DEPTH));

   // scroll decision and cursor advance
   assign is_newline = (req_char_code == gtc_pkg::CODE_NEWLINE);
   assign row_sum    = {1'b0, cursor_row_ff} + ROWS_X;
   assign scroll     = (row_sum >= {1'b0, height_ff});
   assign glyph      = (req_char_code < gtc_pkg::CODE_LIMIT) ?
                       req_char_code[gtc_pkg::GLYPH_W-1:0] : gtc_pkg::CODE_SUBST;

   always_comb begin
      if (!scroll) begin
         row_a = cursor_row_ff;
      end else if ({1'b0, cursor_row_ff} >= ROWS_X) begin
         row_a = cursor_row_ff - CW'(FONT_ROWS);
      end else begin
         row_a = '0;
      end
   end

   assign col_n = {1'b0, cursor_col_ff} + (CW+1)'(gtc_pkg::GLYPH_WIDTH);
   assign row_n = {1'b0, row_a} + ROWS_X;
   assign wrap  = (col_n > {1'b0, width_ff}) || col_n[CW] || is_newline;

   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (char_fire) begin
         if (wrap) begin
            cursor_col_in = '0;
            cursor_row_in = row_n[CW] ? gtc_pkg::COORD_MAX : row_n[CW-1:0];
         end else begin
            cursor_col_in = col_n[CW-1:0];
            cursor_row_in = row_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   // character handed to the sequencer when it gives any beat
   assign load.valid  = char_fire && (scroll || !is_newline);
   assign load.scroll = scroll;
   assign load.draw   = !is_newline;
   assign load.x      = cursor_col_ff;
   assign load.ybase  = row_a;
   assign load.color  = req_ink_color;
   assign load.glyph  = glyph;

   assign advance = !out_valid_ff || !rsp_stall;

   gtc_row_seq #(
      .FONT_ROWS  (FONT_ROWS),
      .NUM_GLYPHS (NUM_GLYPHS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .advance  (advance),
      .stat     (stat),
      .ren      (ren),
      .raddr    (raddr),
      .s1_valid (s1_valid),
      .s1_beat  (s1_beat)
   );

   gtc_glyph_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .wen   (store_fire),
      .waddr (AW'(32'(req_store_addr))),
      .wdata (req_store_byte),
      .ren   (ren),
      .raddr (raddr),
      .rdata (rdata)
   );

   // output register, the mask joins here from the memory read
   always_comb begin
      out_valid_in = out_valid_ff;
      out_beat_in  = out_beat_ff;
      out_mask_in  = out_mask_ff;
      if (advance) begin
         out_valid_in = s1_valid;
         out_beat_in  = s1_beat;
         out_mask_in  = (s1_beat.kind == gtc_pkg::KIND_SCROLL) ? 8'd0 : rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_beat_ff <= out_beat_in;
      out_mask_ff <= out_mask_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_beat_ff.kind;
   assign rsp_pixel_x   = out_beat_ff.x;
   assign rsp_pixel_y   = out_beat_ff.y;
   assign rsp_row_mask  = out_mask_ff;
   assign rsp_pen_color = out_beat_ff.color;
   assign rsp_last      = out_beat_ff.last;

   // scroll beats carry no position, mask or color
   a_scroll_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == gtc_pkg::KIND_SCROLL) |->
      (rsp_row_mask == 8'd0 && rsp_pixel_x == '0 && rsp_pixel_y == '0 &&
       rsp_pen_color == '0))
      else $error("scroll beat with nonzero fields");

   // the cursor column stays on a glyph boundary
   a_col_aligned: assert property (@(posedge clock) disable iff (reset)
      cursor_col_ff[2:0] == 3'd0)
      else $error("cursor column off glyph boundary");

   // the sequencer only goes idle after issuing a final beat
   a_idle_after_final: assert property (@(posedge clock) disable iff (reset)
      $fell(stat.busy) |-> $past(stat.final_issue))
      else $error("sequencer went idle without a final beat");

endmodule

// File: tb/tb_glyph_text_console_unit.sv
`timescale 1ns / 1ps
// tb_glyph_text_console_unit: self-checking bench for the glyph text console
// loads a small glyph set, then streams characters under several screen setups
// depends on gtc_pkg and glyph_text_console_unit
module tb_glyph_text_console_unit;

   localparam int FONT_ROWS   = 16;
   localparam int NUM_GLYPHS  = 128;
   localparam int STORE_DEPTH = NUM_GLYPHS * FONT_ROWS;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int SET_SIZE    = 6;

   typedef struct packed {
      logic                         typ;
      logic [gtc_pkg::CODE_W-1:0]   code;
      logic [gtc_pkg::COLOR_W-1:0]  ink;
      logic [gtc_pkg::STORE_AW-1:0] addr;
      logic [gtc_pkg::MASK_W-1:0]   store_byte;
   } console_req_type;

   typedef struct packed {
      logic                        kind;
      logic [gtc_pkg::COORD_W-1:0] x;
      logic [gtc_pkg::COORD_W-1:0] y;
      logic [gtc_pkg::MASK_W-1:0]  mask;
      logic [gtc_pkg::COLOR_W-1:0] color;
      logic                        last;
   } console_rsp_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_type = 1'b0;
   logic [gtc_pkg::CODE_W-1:0]   req_char_code = '0;
   logic [gtc_pkg::COLOR_W-1:0]  req_ink_color = '0;
   logic [gtc_pkg::STORE_AW-1:0] req_store_addr = '0;
   logic [gtc_pkg::MASK_W-1:0]   req_store_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_kind;
   logic [gtc_pkg::COORD_W-1:0]  rsp_pixel_x;
   logic [gtc_pkg::COORD_W-1:0]  rsp_pixel_y;
   logic [gtc_pkg::MASK_W-1:0]   rsp_row_mask;
   logic [gtc_pkg::COLOR_W-1:0]  rsp_pen_color;
   logic                         rsp_last;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [3:0]                   paddr = '0;
   logic [31:0]                  pwdata = '0;
   logic [31:0]                  prdata;
   logic                         pready;

   // shadow of the block: registers, cursor and glyph store
   logic                         cfg_enable = gtc_pkg::RST_ENABLE;
   logic [gtc_pkg::COORD_W-1:0]  cfg_width  = gtc_pkg::RST_WIDTH;
   logic [gtc_pkg::COORD_W-1:0]  cfg_height = gtc_pkg::RST_HEIGHT;
   logic [gtc_pkg::COORD_W-1:0]  cur_col = '0;
   logic [gtc_pkg::COORD_W-1:0]  cur_row = '0;
   logic [gtc_pkg::MASK_W-1:0]   font_img [0:STORE_DEPTH-1];

   console_req_type char_pend_q [$];
   console_rsp_type draw_expect_q [$];

   bit          idle_on = 1'b1;
   bit          hold_go = 1'b0;
   bit          hold_on = 1'b0;
   bit          req_took = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_gap = 0;
   int unsigned miss_count = 0;
   int unsigned beat_count = 0;
   console_req_type next_req;
   console_rsp_type got_rsp;
   console_rsp_type want_rsp;

   glyph_text_console_unit #(
      .FONT_ROWS (FONT_ROWS),
      .NUM_GLYPHS(NUM_GLYPHS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_ink_color (req_ink_color),
      .req_store_addr(req_store_addr),
      .req_store_byte(req_store_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_row_mask  (rsp_row_mask),
      .rsp_pen_color (rsp_pen_color),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // glyphs that get loaded; only these are ever drawn
   function automatic logic [gtc_pkg::GLYPH_W-1:0] set_glyph(input int unsigned k);
      case (k)
         0:       set_glyph = 7'h00;
         1:       set_glyph = 7'h20;
         2:       set_glyph = gtc_pkg::CODE_SUBST;
         3:       set_glyph = 7'h41;
         4:       set_glyph = 7'h42;
         default: set_glyph = 7'h7E;
      endcase
   endfunction

   // store writes update the shadow store; else, when enabled, scroll check, glyph rows, then cursor advance and wrap
   task automatic predict_console(input console_req_type it);
      int unsigned beats;
      int unsigned k;
      int unsigned ycalc;
      int unsigned col_next;
      int unsigned row_next;
      bit          need_scroll;
      bit          is_newline;
      logic [gtc_pkg::GLYPH_W-1:0] glyph;
      console_rsp_type r;
      if (it.typ == gtc_pkg::REQ_STORE) begin
         if (int'(it.addr) < STORE_DEPTH) font_img[it.addr] = it.store_byte;
         return;
      end
      if (!cfg_enable) return;
      is_newline  = (it.code == gtc_pkg::CODE_NEWLINE);
      need_scroll = (int'(cur_row) + FONT_ROWS >= int'(cfg_height));
      beats = (need_scroll ? 1 : 0) + (is_newline ? 0 : FONT_ROWS);
      k = 0;
      if (need_scroll) begin
         r = '0;
         r.kind = gtc_pkg::KIND_SCROLL;
         k++;
         r.last = (k == beats);
         draw_expect_q.push_back(r);
         cur_row = (cur_row >= FONT_ROWS) ? cur_row - FONT_ROWS : '0;
      end
      if (!is_newline) begin
         glyph = (it.code < gtc_pkg::CODE_LIMIT) ? it.code[gtc_pkg::GLYPH_W-1:0] :
                 gtc_pkg::CODE_SUBST;
         for (int i = 0; i < FONT_ROWS; i++) begin
            ycalc   = int'(cur_row) + i;
            r       = '0;
            r.kind  = gtc_pkg::KIND_DRAW;
            r.x     = cur_col;
            r.y     = ycalc[gtc_pkg::COORD_W-1:0];
            r.mask  = font_img[int'(glyph) * FONT_ROWS + i];
            r.color = it.ink;
            k++;
            r.last  = (k == beats);
            draw_expect_q.push_back(r);
         end
      end
      col_next = int'(cur_col) + gtc_pkg::GLYPH_WIDTH;
      if (col_next > cfg_width || col_next > gtc_pkg::COORD_MAX || is_newline) begin
         cur_col  = '0;
         row_next = int'(cur_row) + FONT_ROWS;
         cur_row  = (row_next > gtc_pkg::COORD_MAX) ? gtc_pkg::COORD_MAX :
                    row_next[gtc_pkg::COORD_W-1:0];
      end else begin
         cur_col = col_next[gtc_pkg::COORD_W-1:0];
      end
   endtask

   task automatic report_miss(input string what);
      if (miss_count < 10) $display("%s", what);
      miss_count++;
   endtask

   // request driver: hold a stalled beat, else maybe idle, else present the next item
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // stalled beat stays as it is
      end else if (send_gap > 0) begin
         send_gap  <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (char_pend_q.size() > 0 && !(idle_on && $urandom_range(0, 4) == 0)) begin
         next_req = char_pend_q.pop_front();
         req_type       <= next_req.typ;
         req_char_code  <= next_req.code;
         req_ink_color  <= next_req.ink;
         req_store_addr <= next_req.addr;
         req_store_byte <= next_req.store_byte;
         req_valid      <= 1'b1;
      end else begin
         if (char_pend_q.size() > 0) send_gap <= $urandom_range(0, 3);
         req_valid <= 1'b0;
      end
   end

   // accepted request beats feed the predictor
   always @(posedge clock) begin
      req_took <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         predict_console('{req_type, req_char_code, req_ink_color,
                           req_store_addr, req_store_byte});
   end

   // result stall: long hold-off on request, else short random bursts
   always @(negedge clock) begin
      if (hold_on) begin
         rsp_stall <= 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap <= stall_gap - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_gap <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // long receiver hold-off, counted here
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on = 1'b0;
   end

   // result monitor: compare each beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rsp = '{rsp_kind, rsp_pixel_x, rsp_pixel_y, rsp_row_mask,
                     rsp_pen_color, rsp_last};
         if (draw_expect_q.size() == 0) begin
            report_miss($sformatf("result %0d arrived with nothing expected", beat_count));
         end else begin
            want_rsp = draw_expect_q.pop_front();
            if (got_rsp !== want_rsp)
               report_miss($sformatf({"result %0d: expected kind %0d x %0d y %0d ",
                  "mask %02h color %08h last %0d, got kind %0d x %0d y %0d ",
                  "mask %02h color %08h last %0d"},
                  beat_count, want_rsp.kind, want_rsp.x, want_rsp.y, want_rsp.mask,
                  want_rsp.color, want_rsp.last, got_rsp.kind, got_rsp.x, got_rsp.y,
                  got_rsp.mask, got_rsp.color, got_rsp.last));
         end
         beat_count++;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      case (idx)
         gtc_pkg::REG_ENABLE: cfg_enable = val[0];
         gtc_pkg::REG_WIDTH:  cfg_width  = val[gtc_pkg::COORD_W-1:0];
         gtc_pkg::REG_HEIGHT: cfg_height = val[gtc_pkg::COORD_W-1:0];
         default: ;
      endcase
   endtask

   // wait until every item is taken and every result is back, then let the block settle
   task automatic drain_console();
      while (char_pend_q.size() != 0 || req_valid || draw_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_char(input logic [gtc_pkg::CODE_W-1:0] code,
                            input logic [gtc_pkg::COLOR_W-1:0] ink);
      console_req_type it;
      it.typ        = gtc_pkg::REQ_CHAR;
      it.code       = code;
      it.ink        = ink;
      it.addr       = $urandom_range(0, STORE_DEPTH - 1);
      it.store_byte = $urandom_range(0, 255);
      char_pend_q.push_back(it);
   endtask

   task automatic push_store(input logic [gtc_pkg::STORE_AW-1:0] addr,
                             input logic [gtc_pkg::MASK_W-1:0] val);
      console_req_type it;
      it.typ        = gtc_pkg::REQ_STORE;
      it.code       = $urandom_range(0, 21'h1FFFFF);
      it.ink        = $urandom;
      it.addr       = addr;
      it.store_byte = val;
      char_pend_q.push_back(it);
   endtask

   // row address inside the loaded glyph set
   function automatic logic [gtc_pkg::STORE_AW-1:0] set_addr(input int unsigned k,
                                                             input int unsigned row);
      set_addr = gtc_pkg::STORE_AW'(int'(set_glyph(k)) * FONT_ROWS + int'(row));
   endfunction

   // mostly ordinary text with newlines, some odd codes and glyph rewrites
   task automatic push_random(input int unsigned count, input int unsigned store_pct);
      logic [gtc_pkg::CODE_W-1:0] code;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < store_pct) begin
            push_store(set_addr($urandom_range(0, SET_SIZE - 1),
                                $urandom_range(0, FONT_ROWS - 1)),
                       $urandom_range(0, 255));
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2: code = gtc_pkg::CODE_NEWLINE;
               3, 4:    code = $urandom_range(21'h7F, 21'h1FFFFF);
               5:       code = $urandom_range(21'h7F, 21'hFF);
               default: code = gtc_pkg::CODE_W'(set_glyph($urandom_range(0, SET_SIZE - 1)));
            endcase
            push_char(code, $urandom);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // the glyph set first, so every later read hits written rows
      for (int g = 0; g < SET_SIZE; g++)
         for (int r = 0; r < FONT_ROWS; r++)
            push_store(set_addr(g, r), $urandom_range(0, 255));
      // directed: extremes of codes, masks and colours under reset settings
      push_store(0, 8'h00);
      push_store(STORE_DEPTH - 1, 8'hFF);
      push_store(21'h41 * FONT_ROWS, 8'h80);
      push_store(21'h41 * FONT_ROWS + FONT_ROWS - 1, 8'h01);
      push_char(21'h00, 32'h0000_0000);
      push_char(21'h41, 32'hFFFF_FFFF);
      push_char(21'h7E, $urandom);
      push_char(gtc_pkg::CODE_LIMIT, $urandom);
      push_char(21'h1FFFFF, $urandom);
      push_char(gtc_pkg::CODE_NEWLINE, $urandom);
      push_char(gtc_pkg::CODE_NEWLINE, $urandom);
      push_char(21'h20, $urandom);
      push_char(21'h3F, $urandom);
      drain_console();

      // smallest screen: a scroll on every character, wrap every other one
      csr_write(gtc_pkg::REG_ENABLE, 32'd1);
      csr_write(gtc_pkg::REG_WIDTH, 32'd8);
      csr_write(gtc_pkg::REG_HEIGHT, 32'd16);
      push_char(21'h41, $urandom);
      push_char(21'h42, $urandom);
      push_char(gtc_pkg::CODE_NEWLINE, $urandom);
      push_random(30, 15);
      drain_console();

      // largest screen, with the receiver holding off to back up the block
      csr_write(gtc_pkg::REG_WIDTH, 32'd4096);
      csr_write(gtc_pkg::REG_HEIGHT, 32'd4096);
      hold_go = 1'b1;
      push_random(40, 10);
      drain_console();

      // disabled: characters vanish, store writes still land
      csr_write(gtc_pkg::REG_ENABLE, 32'd0);
      push_random(25, 40);
      drain_console();

      // mid-size screens with frequent wrap and scroll
      csr_write(gtc_pkg::REG_ENABLE, 32'd1);
      csr_write(gtc_pkg::REG_WIDTH, $urandom_range(8, 160));
      csr_write(gtc_pkg::REG_HEIGHT, $urandom_range(16, 160));
      push_random(35, 15);
      drain_console();
      csr_write(gtc_pkg::REG_WIDTH, $urandom_range(8, 160));
      csr_write(gtc_pkg::REG_HEIGHT, 32'd16);
      push_random(20, 15);
      drain_console();
      csr_write(gtc_pkg::REG_HEIGHT, $urandom_range(16, 160));
      push_random(30, 15);
      drain_console();

      // back to defaults, no idling on either side
      csr_write(gtc_pkg::REG_WIDTH, 32'(gtc_pkg::RST_WIDTH));
      csr_write(gtc_pkg::REG_HEIGHT, 32'(gtc_pkg::RST_HEIGHT));
      idle_on = 1'b0;
      push_random(40, 10);
      drain_console();

      if (miss_count == 0)
         $display("glyph_text_console_unit: match");
      else
         $display("glyph_text_console_unit: mismatch");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("glyph_text_console_unit: mismatch");
      $finish;
   end

endmodule

// File: sim.f
design/gtc_pkg.sv
design/gtc_glyph_mem.sv
design/gtc_row_seq.sv
design/glyph_text_console_unit.sv
tb/tb_glyph_text_console_unit.sv
